// ===== rtl/psp_pkg.sv =====
// ----------------------------------------------------------------------------
// psp_pkg
// Types and constants shared by the point-to-segment proximity test.
// ----------------------------------------------------------------------------
package psp_pkg;

    // Coordinate width; the datapath holds for any value from 8 to 24
    localparam int COORD_BITS = 16;

    localparam int TOL_BITS  = 8;
    localparam int TOL2_BITS = 2 * TOL_BITS;

    localparam logic [TOL_BITS-1:0]  TOL_RESET  = 8'd5;
    localparam logic [TOL2_BITS-1:0] TOL2_RESET = TOL2_BITS'(TOL_RESET * TOL_RESET);

    typedef enum logic [1:0] {
        PART_START    = 2'd0,
        PART_INTERIOR = 2'd1,
        PART_END      = 2'd2
    } t_part;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
    } t_in_item;

    typedef struct packed {
        logic  hit;
        t_part nearest_part;
    } t_out_item;

endpackage

// ===== rtl/point_segment_proximity_test_top.sv =====
// Throughput: one transaction per cycle while the input is not stalled.
// Empty stages fill even while the output is stalled.
// Each stage moves on when it is empty or the stage after it moves on.
// Reset (synchronous, active low) empties every stage and sets the tolerance to 5.
// The tolerance squared is formed once, at the configuration write.
// ----------------------------------------------------------------------------
// point_segment_proximity_test_top
// Six-stage pipeline that tests whether a point lies within the tolerance of
// a segment and reports the nearest part, using exact integer arithmetic.
// ----------------------------------------------------------------------------
module point_segment_proximity_test_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input items
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  psp_pkg::t_in_item          i_in_data,
    // results
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output psp_pkg::t_out_item         o_out_data,
    // tolerance register
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [psp_pkg::TOL_BITS-1:0] i_cfg_data
);

    localparam int C    = psp_pkg::COORD_BITS;
    localparam int NSTG = 6;
    localparam int DW   = C + 1;          // coordinate difference
    localparam int PW   = 2 * C + 2;      // product of two differences
    localparam int LW   = 2 * C + 2;      // squared length or distance
    localparam int SW   = 2 * C + 3;      // dot and cross
    localparam int MW   = SW - 1;         // magnitude of cross
    localparam int K    = (MW + 1) / 2;   // low half of the magnitude
    localparam int HW   = MW - K;         // high half of the magnitude
    localparam int RW   = psp_pkg::TOL2_BITS + LW;
    localparam int CW   = 2 * MW;         // cross squared

    // ---------------------------------------------------------------- control
    logic [NSTG:1] r_vld;
    logic [NSTG:1] w_adv;

    always_comb begin
        w_adv[NSTG] = !r_vld[NSTG] || !i_out_stall;
        for (int k = NSTG - 1; k >= 1; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    assign o_in_stall  = !w_adv[1];
    assign o_out_valid = r_vld[NSTG];
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[1]) begin
                r_vld[1] <= i_in_valid;
            end
            for (int k = 2; k <= NSTG; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // -------------------------------------------------------------- tolerance
    logic [psp_pkg::TOL2_BITS-1:0] r_tol2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol2 <= psp_pkg::TOL2_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_tol2 <= psp_pkg::TOL2_BITS'(i_cfg_data) * psp_pkg::TOL2_BITS'(i_cfg_data);
        end
    end

    // ------------------------------------------------ stage 1: differences
    logic signed [DW-1:0] r_abx1, r_aby1, r_apx1, r_apy1, r_bpx1, r_bpy1;

    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r_abx1 <= DW'($signed(i_in_data.end_x))   - DW'($signed(i_in_data.start_x));
            r_aby1 <= DW'($signed(i_in_data.end_y))   - DW'($signed(i_in_data.start_y));
            r_apx1 <= DW'($signed(i_in_data.point_x)) - DW'($signed(i_in_data.start_x));
            r_apy1 <= DW'($signed(i_in_data.point_y)) - DW'($signed(i_in_data.start_y));
            r_bpx1 <= DW'($signed(i_in_data.point_x)) - DW'($signed(i_in_data.end_x));
            r_bpy1 <= DW'($signed(i_in_data.point_y)) - DW'($signed(i_in_data.end_y));
        end
    end

    // --------------------------------------------------- stage 2: products
    logic signed [PW-1:0] r_abx2_2, r_aby2_2, r_dotx2, r_doty2, r_crsa2, r_crsb2;
    logic signed [PW-1:0] r_apx2_2, r_apy2_2, r_bpx2_2, r_bpy2_2;

    always_ff @(posedge i_clk) begin
        if (w_adv[2]) begin
            r_abx2_2 <= PW'(r_abx1) * PW'(r_abx1);
            r_aby2_2 <= PW'(r_aby1) * PW'(r_aby1);
            r_dotx2  <= PW'(r_apx1) * PW'(r_abx1);
            r_doty2  <= PW'(r_apy1) * PW'(r_aby1);
            r_crsa2  <= PW'(r_apx1) * PW'(r_aby1);
            r_crsb2  <= PW'(r_apy1) * PW'(r_abx1);
            r_apx2_2 <= PW'(r_apx1) * PW'(r_apx1);
            r_apy2_2 <= PW'(r_apy1) * PW'(r_apy1);
            r_bpx2_2 <= PW'(r_bpx1) * PW'(r_bpx1);
            r_bpy2_2 <= PW'(r_bpy1) * PW'(r_bpy1);
        end
    end

    // ------------------------------------------------------- stage 3: sums
    logic        [LW-1:0] r_len2_3, r_d2s3, r_d2e3;
    logic signed [SW-1:0] r_dot3, r_cross3;

    always_ff @(posedge i_clk) begin
        if (w_adv[3]) begin
            r_len2_3 <= LW'($unsigned(r_abx2_2)) + LW'($unsigned(r_aby2_2));
            r_d2s3   <= LW'($unsigned(r_apx2_2)) + LW'($unsigned(r_apy2_2));
            r_d2e3   <= LW'($unsigned(r_bpx2_2)) + LW'($unsigned(r_bpy2_2));
            r_dot3   <= SW'(r_dotx2) + SW'(r_doty2);
            r_cross3 <= SW'(r_crsa2) - SW'(r_crsb2);
        end
    end

    // ------------------------- stage 4: part, endpoint test, tol^2 * len^2
    logic                  w_dot_le0, w_dot_ge;
    psp_pkg::t_part        n_part4;
    logic [LW-1:0]         w_d2;

    psp_pkg::t_part        r_part4;
    logic                  r_hit_ep4;
    logic [MW-1:0]         r_mag4;
    logic [RW-1:0]         r_rhs4;

    always_comb begin
        w_dot_le0 = (r_dot3 <= 0);
        w_dot_ge  = (r_dot3 >= $signed(SW'(r_len2_3)));
        if (w_dot_le0) begin
            n_part4 = psp_pkg::PART_START;
        end else if (w_dot_ge) begin
            n_part4 = psp_pkg::PART_END;
        end else begin
            n_part4 = psp_pkg::PART_INTERIOR;
        end
        w_d2 = (n_part4 == psp_pkg::PART_END) ? r_d2e3 : r_d2s3;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[4]) begin
            r_part4   <= n_part4;
            r_hit_ep4 <= (w_d2 <= LW'(r_tol2));
            r_mag4    <= r_cross3[SW-1] ? MW'(-r_cross3) : MW'(r_cross3);
            r_rhs4    <= RW'(r_tol2) * RW'(r_len2_3);
        end
    end

    // ---------------------------------- stage 5: partial products of cross^2
    logic [HW-1:0]     w_mag_hi;
    logic [K-1:0]      w_mag_lo;

    psp_pkg::t_part    r_part5;
    logic              r_hit_ep5;
    logic [RW-1:0]     r_rhs5;
    logic [2*HW-1:0]   r_hh5;
    logic [HW+K-1:0]   r_hl5;
    logic [2*K-1:0]    r_ll5;

    assign w_mag_hi = r_mag4[MW-1:K];
    assign w_mag_lo = r_mag4[K-1:0];

    always_ff @(posedge i_clk) begin
        if (w_adv[5]) begin
            r_part5   <= r_part4;
            r_hit_ep5 <= r_hit_ep4;
            r_rhs5    <= r_rhs4;
            r_hh5     <= (2*HW)'(w_mag_hi) * (2*HW)'(w_mag_hi);
            r_hl5     <= (HW+K)'(w_mag_hi) * (HW+K)'(w_mag_lo);
            r_ll5     <= (2*K)'(w_mag_lo)  * (2*K)'(w_mag_lo);
        end
    end

    // ------------------------------------ stage 6: interior test and output
    logic [CW-1:0]     w_lhs;
    logic              n_hit6;
    logic              r_hit6;
    psp_pkg::t_part    r_part6;

    always_comb begin
        w_lhs = (CW'(r_hh5) << (2*K)) + (CW'(r_hl5) << (K+1)) + CW'(r_ll5);
        if (r_part5 == psp_pkg::PART_INTERIOR) begin
            n_hit6 = (w_lhs <= CW'(r_rhs5));
        end else begin
            n_hit6 = r_hit_ep5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[6]) begin
            r_hit6  <= n_hit6;
            r_part6 <= r_part5;
        end
    end

    assign o_out_data.hit          = r_hit6;
    assign o_out_data.nearest_part = r_part6;

    // ------------------------------------------------------------ assertions
    // A degenerate segment always projects to zero
    a_degenerate_dot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[3] && (r_len2_3 == '0) |-> (r_dot3 == '0))
        else $error("zero-length segment with non-zero projection");

    // The input stalls only when every stage holds a transaction
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (&r_vld))
        else $error("input stalled with an empty stage");

    // Back-pressure originates only at the output
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> i_out_stall)
        else $error("input stalled without output stall");

    // A held stage keeps its transaction
    a_hold_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[4] && !w_adv[4] |=> r_vld[4])
        else $error("stalled transaction dropped");

endmodule

// ===== tb/tb_point_segment_proximity_test_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_point_segment_proximity_test_top
// Self-checking bench for the point-to-segment proximity pipeline. A local
// integer predictor forms the expected hit flag and nearest part for every
// accepted input transaction. A monitor compares each accepted result with
// the oldest expectation, under random idling, a long output hold-off and
// several tolerance settings.
// ----------------------------------------------------------------------------
module tb_point_segment_proximity_test_top;

    localparam int CLK_HALF    = 6;
    localparam int RESET_CYCLES = 6;
    localparam int PIPE_DEPTH  = 6;
    localparam int CYCLE_LIMIT = 400000;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_in_valid = 1'b0;
    logic                         o_in_stall;
    psp_pkg::t_in_item            i_in_data = '0;
    logic                         o_out_valid;
    logic                         i_out_stall = 1'b0;
    psp_pkg::t_out_item           o_out_data;
    logic                         i_cfg_valid = 1'b0;
    logic                         o_cfg_ready;
    logic [psp_pkg::TOL_BITS-1:0] i_cfg_data = '0;

    psp_pkg::t_out_item           pending_results[$];
    logic [psp_pkg::TOL_BITS-1:0] tol_shadow = psp_pkg::TOL_RESET;
    int                           error_count = 0;
    int                           cycle_count = 0;
    int                           send_idle_pct = 0;
    int                           stall_pct = 0;
    int                           hold_left = 0;

    point_segment_proximity_test_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Exact distance test: projection decides the nearest part, then either
    // squared endpoint distance or cross squared against tol^2 * len^2.
    function automatic psp_pkg::t_out_item proximity_of(
        input psp_pkg::t_in_item seg, input logic [psp_pkg::TOL_BITS-1:0] tol);
        longint             abx, aby, apx, apy, bpx, bpy, len2, dot, crs, d2;
        longint unsigned    tol2;
        logic [127:0]       mag, lhs, rhs;
        psp_pkg::t_out_item res;
        abx  = longint'($signed(seg.end_x)) - longint'($signed(seg.start_x));
        aby  = longint'($signed(seg.end_y)) - longint'($signed(seg.start_y));
        apx  = longint'($signed(seg.point_x)) - longint'($signed(seg.start_x));
        apy  = longint'($signed(seg.point_y)) - longint'($signed(seg.start_y));
        len2 = abx * abx + aby * aby;
        dot  = apx * abx + apy * aby;
        tol2 = longint'(tol) * longint'(tol);
        if (dot <= 0) begin
            d2 = apx * apx + apy * apy;
            res.nearest_part = psp_pkg::PART_START;
            res.hit = ($unsigned(d2) <= tol2);
        end else if (dot >= len2) begin
            bpx = longint'($signed(seg.point_x)) - longint'($signed(seg.end_x));
            bpy = longint'($signed(seg.point_y)) - longint'($signed(seg.end_y));
            d2  = bpx * bpx + bpy * bpy;
            res.nearest_part = psp_pkg::PART_END;
            res.hit = ($unsigned(d2) <= tol2);
        end else begin
            crs = apx * aby - apy * abx;
            mag = 128'((crs < 0) ? -crs : crs);
            lhs = mag * mag;
            rhs = 128'(tol2) * 128'(len2);
            res.nearest_part = psp_pkg::PART_INTERIOR;
            res.hit = (lhs <= rhs);
        end
        return res;
    endfunction

    // Check results first, then record the new transaction, so a spurious
    // result is never matched against an item accepted at the same edge.
    always @(posedge i_clk) begin : result_monitor
        psp_pkg::t_out_item want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result, expected none actual hit %0b part %0d",
                             $time, o_out_data.hit, o_out_data.nearest_part);
                end else begin
                    want = pending_results.pop_front();
                    if (o_out_data.hit !== want.hit) begin
                        error_count++;
                        $display("%0t: hit mismatch, expected %0b actual %0b",
                                 $time, want.hit, o_out_data.hit);
                    end
                    if (o_out_data.nearest_part !== want.nearest_part) begin
                        error_count++;
                        $display("%0t: nearest_part mismatch, expected %0d actual %0d",
                                 $time, want.nearest_part, o_out_data.nearest_part);
                    end
                end
            end
            if (i_in_valid && !o_in_stall)
                pending_results.push_back(proximity_of(i_in_data, tol_shadow));
            if (i_cfg_valid && o_cfg_ready)
                tol_shadow = i_cfg_data;
        end
    end

    // Receiver: a long hold-off takes precedence over random stalling
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall = 1'b0;
        end else if (hold_left > 0) begin
            i_out_stall = 1'b1;
            hold_left--;
        end else begin
            i_out_stall = ($urandom_range(99) < stall_pct);
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance
    // with valid still high, so the caller either follows on or drops it.
    task automatic send_item(input psp_pkg::t_in_item item);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data  = item;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic drain;
        i_in_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 4) @(negedge i_clk);
    endtask

    task automatic write_tolerance(input logic [psp_pkg::TOL_BITS-1:0] value);
        drain();
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic int spread(input int m);
        return int'($urandom_range(2 * m)) - m;
    endfunction

    function automatic psp_pkg::t_in_item segment_item(
        input int sx, input int sy, input int ex,
        input int ey, input int px, input int py);
        psp_pkg::t_in_item it;
        it.point_x = psp_pkg::COORD_BITS'(px);
        it.point_y = psp_pkg::COORD_BITS'(py);
        it.start_x = psp_pkg::COORD_BITS'(sx);
        it.start_y = psp_pkg::COORD_BITS'(sy);
        it.end_x   = psp_pkg::COORD_BITS'(ex);
        it.end_y   = psp_pkg::COORD_BITS'(ey);
        return it;
    endfunction

    // Mostly short segments with the point near them; the rest is raw noise
    function automatic psp_pkg::t_in_item random_item();
        int                kind, bx, by, ex, ey, span, reach;
        psp_pkg::t_in_item it;
        kind = $urandom_range(9);
        if (kind < 2) begin
            it = {$urandom, $urandom, $urandom};
        end else begin
            bx    = int'($urandom_range(60000)) - 30000;
            by    = int'($urandom_range(60000)) - 30000;
            span  = (kind < 6) ? 16 : 400;
            ex    = (kind == 2) ? bx : bx + spread(span);
            ey    = (kind == 2) ? by : by + spread(span);
            reach = span + int'(tol_shadow) + 2;
            it    = segment_item(bx, by, ex, ey, bx + spread(reach), by + spread(reach));
        end
        return it;
    endfunction

    task automatic run_random(input int count, input int idle_pct, input int stall);
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        repeat (count) send_item(random_item());
        i_in_valid = 1'b0;
    endtask

    task automatic test_directed;
        send_idle_pct = 0;
        stall_pct     = 0;
        // zero-length segment, on and off the start point
        send_item(segment_item(7, -9, 7, -9, 7, -9));
        send_item(segment_item(7, -9, 7, -9, 10, -5));
        send_item(segment_item(7, -9, 7, -9, 10, -4));
        // projection exactly on each endpoint
        send_item(segment_item(0, 0, 10, 0, 0, 3));
        send_item(segment_item(0, 0, 10, 0, 10, 4));
        // interior on and just past the tolerance
        send_item(segment_item(0, 0, 10, 0, 5, 5));
        send_item(segment_item(0, 0, 10, 0, 5, 6));
        send_item(segment_item(0, 0, 10, 0, 5, -5));
        // endpoint distance on and just past the tolerance
        send_item(segment_item(0, 0, 10, 0, -3, -4));
        send_item(segment_item(0, 0, 10, 0, -3, -5));
        send_item(segment_item(0, 0, 10, 0, 13, 4));
        send_item(segment_item(0, 0, 10, 0, 13, 5));
        // diagonal interior, exact cross product check
        send_item(segment_item(-100, -100, 100, 100, 3, -4));
        // extremes of the coordinate range
        send_item(segment_item(-32768, -32768, 32767, 32767, 32767, -32768));
        send_item(segment_item(32767, 32767, -32768, -32768, -32768, 32767));
        send_item(segment_item(-32768, -32768, 32767, 32767, 0, 0));
        send_item(segment_item(-32768, 32767, 32767, -32768, -32768, -32768));
        send_item(segment_item(-32768, 0, 32767, 0, 32767, 32767));
        send_item(segment_item(32767, -32768, 32767, -32768, -32768, 32767));
        send_item(segment_item(-32768, -32768, -32767, -32768, 32767, -32768));
        send_item(segment_item(0, 0, 0, 1, 0, 1));
        drain();
    endtask

    task automatic test_tolerance_settings;
        run_random(200, 0, 0);
        write_tolerance(8'd0);
        run_random(150, 79, 0);
        write_tolerance(8'd255);
        run_random(200, 0, 79);
        write_tolerance(8'($urandom_range(2, 254)));
        run_random(200, 31, 31);
        write_tolerance(8'd1);
        run_random(60, 0, 0);
        drain();
    endtask

    task automatic test_backpressure;
        write_tolerance(8'd5);
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_left     = 300;
        repeat (40) send_item(random_item());
        i_in_valid = 1'b0;
        drain();
    endtask

    task automatic test_mixed_idling;
        write_tolerance(8'($urandom_range(255)));
        repeat (6) run_random(25, $urandom_range(79), $urandom_range(79));
        drain();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_directed();
        test_tolerance_settings();
        test_backpressure();
        test_mixed_idling();
        stall_pct = 0;
        drain();
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== point_segment_proximity_test_top.f =====
rtl/psp_pkg.sv
rtl/point_segment_proximity_test_top.sv
tb/tb_point_segment_proximity_test_top.sv
